/* src/cnc_response_line_classifier_assert.svh */
// assertion macros shared by the response line classifier modules
`ifndef CNC_RESPONSE_LINE_CLASSIFIER_ASSERT_SVH
`define CNC_RESPONSE_LINE_CLASSIFIER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define RLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define RLC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* src/cnc_rlc_pkg.sv */
// shared types, character codes and literal tables of the response line classifier
package cnc_rlc_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // line positions that matter to the keyword matchers
  localparam logic [2:0] POS_OK_LEN    = 3'd2;
  localparam logic [2:0] POS_READY_LEN = 3'd5;
  localparam logic [2:0] POS_PREFIX    = 3'd6;
  localparam logic [2:0] POS_SAT       = 3'd7;
  localparam logic [5:0] IDLE_LEN      = 6'd4;
  localparam logic [5:0] NAME_MAX      = 6'd63;

  localparam logic [15:0] CODE_MAX = 16'hFFFF;

  // queue depths, powers of two
  localparam int TOKQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_OK      = 3'd0,
    KIND_READY   = 3'd1,
    KIND_STATUS  = 3'd2,
    KIND_ALARM   = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_UNKNOWN = 3'd5
  } line_kind_e;

  // one received character after front classification
  typedef struct packed {
    logic       last;   // newline
    logic       nul;    // zero byte
    logic       digit;  // decimal digit
    logic       blank;  // space or tab .. carriage return
    logic [7:0] data;
  } token_t;

  // one classified line
  typedef struct packed {
    line_kind_e         kind;
    logic signed [16:0] code;
    logic               idle;
    logic [5:0]         name_len;
    logic               ack;
    logic               ready;
  } result_t;

  // keyword characters by position, zero past the end
  function automatic logic [7:0] ok_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6F; // o
      3'd1:    ch = 8'h6B; // k
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ready_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h52; // R
      3'd1:    ch = 8'h45; // E
      3'd2:    ch = 8'h41; // A
      3'd3:    ch = 8'h44; // D
      3'd4:    ch = 8'h59; // Y
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] alarm_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h41; // A
      3'd1:    ch = 8'h4C; // L
      3'd2:    ch = 8'h41; // A
      3'd3:    ch = 8'h52; // R
      3'd4:    ch = 8'h4D; // M
      3'd5:    ch = 8'h3A; // :
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] error_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h65; // e
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h72; // r
      3'd3:    ch = 8'h6F; // o
      3'd4:    ch = 8'h72; // r
      3'd5:    ch = 8'h3A; // :
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] idle_char(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd0:    ch = 8'h49; // I
      6'd1:    ch = 8'h64; // d
      6'd2:    ch = 8'h6C; // l
      6'd3:    ch = 8'h65; // e
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* src/cnc_response_line_classifier.sv */
// top level of the motion controller response line classifier
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------------------
//  rx bytes  | in        | push / full           | rx_byte_i
//  results   | out       | empty / pop           | line_kind_o, reported_code_o,
//            |           |                       | state_is_idle_o, state_name_length_o,
//            |           |                       | ack_released_o, controller_ready_o
//
// one byte is taken every cycle while full is low; every character is matched as it
//   goes by, so nothing is buffered per line and a newline costs no more than any other byte
// a result shows on the output once its newline has passed the front register, the
//   token queue and the back matcher, which writes it into the result queue
// reset clears the line state and the sticky ready flag; no clearing pass is needed
// a held result stalls the back matcher only once the result queue is full; the token
//   queue then absorbs bytes until full rises
module cnc_response_line_classifier #(
  parameter int LINE_MAX = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input, queue style
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  // result output, queue style
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         line_kind_o,
  output logic signed [16:0] reported_code_o,
  output logic               state_is_idle_o,
  output logic [5:0]         state_name_length_o,
  output logic               ack_released_o,
  output logic               controller_ready_o
);

  localparam int TokW = $bits(cnc_rlc_pkg::token_t);
  localparam int ResW = $bits(cnc_rlc_pkg::result_t);

  // front to token queue
  logic                 front_push;
  cnc_rlc_pkg::token_t  front_tok;
  logic                 tokq_full;

  // token queue to back
  logic [TokW-1:0]      tokq_data;
  logic                 tokq_empty;
  logic                 tokq_pop;

  // back to result queue
  logic                 back_push;
  cnc_rlc_pkg::result_t back_res;
  logic                 resq_full;
  logic [ResW-1:0]      resq_data;
  cnc_rlc_pkg::result_t out_res;
  logic                 resq_pop;

  // byte classification, drops carriage returns
  cnc_rlc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .tok_push_o (front_push),
    .tok_o      (front_tok),
    .tok_full_i (tokq_full)
  );

  // decouples byte intake from line matching
  cnc_rlc_fifo #(
    .WIDTH (TokW),
    .DEPTH (cnc_rlc_pkg::TOKQ_DEPTH)
  ) u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_tok),
    .full_o  (tokq_full),
    .pop_i   (tokq_pop),
    .data_o  (tokq_data),
    .empty_o (tokq_empty)
  );

  // incremental line matcher
  cnc_rlc_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!tokq_empty),
    .tok_i       (cnc_rlc_pkg::token_t'(tokq_data)),
    .tok_pop_o   (tokq_pop),
    .res_full_i  (resq_full),
    .res_push_o  (back_push),
    .res_o       (back_res)
  );

  // results wait here until transferred out
  assign resq_pop = pop && !empty;

  cnc_rlc_fifo #(
    .WIDTH (ResW),
    .DEPTH (cnc_rlc_pkg::RESQ_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_push),
    .data_i  (back_res),
    .full_o  (resq_full),
    .pop_i   (resq_pop),
    .data_o  (resq_data),
    .empty_o (empty)
  );

  assign out_res             = cnc_rlc_pkg::result_t'(resq_data);
  assign line_kind_o         = out_res.kind;
  assign reported_code_o     = out_res.code;
  assign state_is_idle_o     = out_res.idle;
  assign state_name_length_o = out_res.name_len;
  assign ack_released_o      = out_res.ack;
  assign controller_ready_o  = out_res.ready;

endmodule

/* src/cnc_rlc_fifo.sv */
// small synchronous queue with registered storage
module cnc_rlc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  `include "cnc_response_line_classifier_assert.svh"

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AddrW:0] CntFull = (AddrW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `RLC_ASSERT_NEVER(a_fifo_no_overflow, push_i && full_o, "push into full queue")
  `RLC_ASSERT_NEVER(a_fifo_no_underflow, pop_i && empty_o, "pop from empty queue")
  `RLC_ASSERT(a_fifo_count_up, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1,
              "queue count did not follow a lone push")

endmodule

/* src/cnc_rlc_front.sv */
// front stage: takes received bytes, drops carriage returns, tags character classes
module cnc_rlc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          rx_byte_i,
  output logic                full_o,
  output logic                tok_push_o,
  output cnc_rlc_pkg::token_t tok_o,
  input  logic                tok_full_i
);

  logic                valid_q, valid_d;
  cnc_rlc_pkg::token_t tok_q, tok_d;
  logic                take;

  assign full_o     = valid_q && tok_full_i;
  assign take       = push_i && !full_o;
  assign tok_push_o = valid_q && !tok_full_i;
  assign tok_o      = tok_q;

  always_comb begin
    tok_d.data  = rx_byte_i;
    tok_d.last  = (rx_byte_i == cnc_rlc_pkg::CH_LF);
    tok_d.nul   = (rx_byte_i == cnc_rlc_pkg::CH_NUL);
    tok_d.digit = (rx_byte_i >= cnc_rlc_pkg::CH_DIG0) && (rx_byte_i <= cnc_rlc_pkg::CH_DIG9);
    tok_d.blank = (rx_byte_i == cnc_rlc_pkg::CH_SPACE) ||
                  ((rx_byte_i >= cnc_rlc_pkg::CH_TAB) && (rx_byte_i <= cnc_rlc_pkg::CH_CR));
    valid_d = valid_q;
    if (take) begin
      valid_d = (rx_byte_i != cnc_rlc_pkg::CH_CR);
    end else if (tok_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q <= tok_d;
    end
  end

endmodule

/* src/cnc_rlc_back.sv */
// back stage: per-character keyword, status and code matching, one result per non-empty line
module cnc_rlc_back #(
  parameter int LINE_MAX = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_valid_i,
  input  cnc_rlc_pkg::token_t  tok_i,
  output logic                 tok_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output cnc_rlc_pkg::result_t res_o
);

  `include "cnc_response_line_classifier_assert.svh"

  localparam int LenW = $clog2(LINE_MAX);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_MAX - 1);

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIGITS,
    PH_DONE
  } code_phase_e;

  logic [LenW-1:0] len_q, len_d;
  logic [2:0]      pos_q, pos_d;         // chars before the first zero byte, saturating
  logic            nul_q, nul_d;
  logic            ok_q, ok_d;
  logic            rdy_q, rdy_d;
  logic            alarm_q, alarm_d;
  logic            err_q, err_d;
  logic            lt_q, lt_d;
  logic            bar_q, bar_d;
  logic [5:0]      name_len_q, name_len_d;
  logic            idle_q, idle_d;
  code_phase_e     phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [15:0]     mag_q, mag_d;
  logic            ready_seen_q, ready_seen_d;

  logic            fire;
  logic            clear_line;
  logic [19:0]     mag_sum;
  logic [15:0]     mag_next;
  logic [16:0]     mag_ext;
  cnc_rlc_pkg::line_kind_e kind;
  logic            is_idle;

  assign fire      = tok_valid_i && !res_full_i;
  assign tok_pop_o = fire;

  // running decimal value, saturating
  assign mag_sum  = 20'(mag_q) * 20'd10 + 20'(tok_i.data[3:0]);
  assign mag_next = (mag_sum > 20'(cnc_rlc_pkg::CODE_MAX)) ? cnc_rlc_pkg::CODE_MAX
                                                          : mag_sum[15:0];
  assign mag_ext  = {1'b0, mag_q};

  // classification of the line gathered so far
  always_comb begin
    is_idle = 1'b0;
    if (ok_q && pos_q == cnc_rlc_pkg::POS_OK_LEN) begin
      kind = cnc_rlc_pkg::KIND_OK;
    end else if (rdy_q && pos_q == cnc_rlc_pkg::POS_READY_LEN) begin
      kind = cnc_rlc_pkg::KIND_READY;
    end else if (lt_q && bar_q) begin
      kind    = cnc_rlc_pkg::KIND_STATUS;
      is_idle = idle_q && (name_len_q == cnc_rlc_pkg::IDLE_LEN);
    end else if (alarm_q && pos_q >= cnc_rlc_pkg::POS_PREFIX) begin
      kind = cnc_rlc_pkg::KIND_ALARM;
    end else if (err_q && pos_q >= cnc_rlc_pkg::POS_PREFIX) begin
      kind = cnc_rlc_pkg::KIND_ERROR;
    end else begin
      kind = cnc_rlc_pkg::KIND_UNKNOWN;
    end
  end

  always_comb begin
    res_o.kind     = kind;
    res_o.code     = '0;
    if (kind == cnc_rlc_pkg::KIND_ALARM || kind == cnc_rlc_pkg::KIND_ERROR) begin
      res_o.code = neg_q ? -mag_ext : mag_ext;
    end
    res_o.idle     = is_idle;
    res_o.name_len = (kind == cnc_rlc_pkg::KIND_STATUS) ? name_len_q : '0;
    res_o.ack      = (kind == cnc_rlc_pkg::KIND_OK) || (kind == cnc_rlc_pkg::KIND_ERROR);
    res_o.ready    = ready_seen_q || (kind == cnc_rlc_pkg::KIND_READY) || is_idle;
  end

  assign res_push_o = fire && tok_i.last && (len_q != '0);

  always_comb begin
    len_d        = len_q;
    pos_d        = pos_q;
    nul_d        = nul_q;
    ok_d         = ok_q;
    rdy_d        = rdy_q;
    alarm_d      = alarm_q;
    err_d        = err_q;
    lt_d         = lt_q;
    bar_d        = bar_q;
    name_len_d   = name_len_q;
    idle_d       = idle_q;
    phase_d      = phase_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    ready_seen_d = ready_seen_q;
    clear_line   = 1'b0;

    if (fire) begin
      if (tok_i.last) begin
        clear_line = 1'b1;
        if (res_push_o) begin
          ready_seen_d = res_o.ready;
        end
      end else if (len_q == LenLast) begin
        // line overflow drops the character and restarts the line
        clear_line = 1'b1;
      end else begin
        len_d = len_q + 1'b1;
        if (!nul_q) begin
          if (tok_i.nul) begin
            nul_d = 1'b1;
          end else begin
            pos_d   = (pos_q == cnc_rlc_pkg::POS_SAT) ? pos_q : pos_q + 3'd1;
            ok_d    = ok_q && (tok_i.data == cnc_rlc_pkg::ok_char(pos_q));
            rdy_d   = rdy_q && (tok_i.data == cnc_rlc_pkg::ready_char(pos_q));
            alarm_d = alarm_q && ((pos_q >= cnc_rlc_pkg::POS_PREFIX) ||
                                  (tok_i.data == cnc_rlc_pkg::alarm_char(pos_q)));
            err_d   = err_q && ((pos_q >= cnc_rlc_pkg::POS_PREFIX) ||
                                (tok_i.data == cnc_rlc_pkg::error_char(pos_q)));
            // status line: name runs from after the '<' up to the first bar
            if (pos_q == '0) begin
              lt_d = (tok_i.data == cnc_rlc_pkg::CH_LT);
            end else if (lt_q && !bar_q) begin
              if (tok_i.data == cnc_rlc_pkg::CH_BAR) begin
                bar_d = 1'b1;
              end else begin
                idle_d = idle_q && (tok_i.data == cnc_rlc_pkg::idle_char(name_len_q));
                if (name_len_q != cnc_rlc_pkg::NAME_MAX) begin
                  name_len_d = name_len_q + 6'd1;
                end
              end
            end
            // number after the six-character prefix
            if (pos_q >= cnc_rlc_pkg::POS_PREFIX) begin
              case (phase_q)
                PH_BLANK: begin
                  if (tok_i.blank) begin
                    phase_d = PH_BLANK;
                  end else if (tok_i.data == cnc_rlc_pkg::CH_PLUS ||
                               tok_i.data == cnc_rlc_pkg::CH_MINUS) begin
                    neg_d   = (tok_i.data == cnc_rlc_pkg::CH_MINUS);
                    phase_d = PH_DIGITS;
                  end else if (tok_i.digit) begin
                    mag_d   = mag_next;
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_DONE;
                  end
                end
                PH_DIGITS: begin
                  if (tok_i.digit) begin
                    mag_d = mag_next;
                  end else begin
                    phase_d = PH_DONE;
                  end
                end
                default: phase_d = PH_DONE;
              endcase
            end
          end
        end
      end
    end

    if (clear_line) begin
      len_d      = '0;
      pos_d      = '0;
      nul_d      = 1'b0;
      ok_d       = 1'b1;
      rdy_d      = 1'b1;
      alarm_d    = 1'b1;
      err_d      = 1'b1;
      lt_d       = 1'b0;
      bar_d      = 1'b0;
      name_len_d = '0;
      idle_d     = 1'b1;
      phase_d    = PH_BLANK;
      neg_d      = 1'b0;
      mag_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      pos_q        <= '0;
      nul_q        <= 1'b0;
      ok_q         <= 1'b1;
      rdy_q        <= 1'b1;
      alarm_q      <= 1'b1;
      err_q        <= 1'b1;
      lt_q         <= 1'b0;
      bar_q        <= 1'b0;
      name_len_q   <= '0;
      idle_q       <= 1'b1;
      phase_q      <= PH_BLANK;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      ready_seen_q <= 1'b0;
    end else begin
      len_q        <= len_d;
      pos_q        <= pos_d;
      nul_q        <= nul_d;
      ok_q         <= ok_d;
      rdy_q        <= rdy_d;
      alarm_q      <= alarm_d;
      err_q        <= err_d;
      lt_q         <= lt_d;
      bar_q        <= bar_d;
      name_len_q   <= name_len_d;
      idle_q       <= idle_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      mag_q        <= mag_d;
      ready_seen_q <= ready_seen_d;
    end
  end

  `RLC_ASSERT(a_back_ready_sticky, ready_seen_q |=> ready_seen_q, "ready flag dropped")
  `RLC_ASSERT(a_back_len_bound, len_q <= LenLast, "line length past its limit")
  `RLC_ASSERT(a_back_status_fields,
              res_push_o && res_o.kind != cnc_rlc_pkg::KIND_STATUS |->
                res_o.name_len == '0 && !res_o.idle,
              "status fields set on a non-status line")

endmodule

/* bench/cnc_rlc_response_checker.sv */
// checker that predicts and compares the classified lines of the response line classifier
module cnc_rlc_response_checker #(
  parameter int LINE_MAX = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [2:0]         line_kind_i,
  input  logic signed [16:0] reported_code_i,
  input  logic               state_is_idle_i,
  input  logic [5:0]         state_name_length_i,
  input  logic               ack_released_i,
  input  logic               controller_ready_i,
  output int                 lines_pending_o,
  output int                 mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]           line_chars [LINE_MAX];
  int unsigned          line_count;
  logic                 ready_flag;
  cnc_rlc_pkg::result_t predicted_lines [$];
  int                   mismatch_total;

  function automatic logic text_at(input int unsigned start, input int unsigned n,
                                   input string lit);
    int unsigned i;
    if (n != lit.len()) return 1'b0;
    for (i = 0; i < n; i++)
      if (line_chars[start + i] != lit[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic starts_with(input int unsigned len, input string lit);
    return (len >= lit.len()) && text_at(0, lit.len(), lit);
  endfunction

  // atoi-style decimal after the prefix, magnitude saturated
  function automatic logic [16:0] atoi_code(input int unsigned pos, input int unsigned len);
    int unsigned mag;
    logic        neg;
    logic [16:0] code;
    mag = 0;
    neg = 1'b0;
    while (pos < len && (line_chars[pos] == cnc_rlc_pkg::CH_SPACE ||
           (line_chars[pos] >= cnc_rlc_pkg::CH_TAB &&
            line_chars[pos] <= cnc_rlc_pkg::CH_CR)))
      pos++;
    if (pos < len && (line_chars[pos] == cnc_rlc_pkg::CH_PLUS ||
                      line_chars[pos] == cnc_rlc_pkg::CH_MINUS)) begin
      neg = (line_chars[pos] == cnc_rlc_pkg::CH_MINUS);
      pos++;
    end
    while (pos < len && line_chars[pos] >= cnc_rlc_pkg::CH_DIG0 &&
           line_chars[pos] <= cnc_rlc_pkg::CH_DIG9) begin
      mag = mag * 10 + (line_chars[pos] - cnc_rlc_pkg::CH_DIG0);
      if (mag > cnc_rlc_pkg::CODE_MAX) mag = cnc_rlc_pkg::CODE_MAX;
      pos++;
    end
    code = mag[16:0];
    if (neg) code = -code;
    return code;
  endfunction

  // judges the gathered line, updates the sticky ready flag
  function automatic cnc_rlc_pkg::result_t classify_line();
    cnc_rlc_pkg::result_t r;
    int unsigned          len;
    int unsigned          bar;
    r = '0;
    r.kind = cnc_rlc_pkg::KIND_UNKNOWN;
    len = 0;
    while (len < line_count && line_chars[len] != cnc_rlc_pkg::CH_NUL) len++;
    if (text_at(0, len, "ok")) begin
      r.kind = cnc_rlc_pkg::KIND_OK;
      r.ack = 1'b1;
    end else if (text_at(0, len, "READY")) begin
      r.kind = cnc_rlc_pkg::KIND_READY;
      ready_flag = 1'b1;
    end else if (len > 0 && line_chars[0] == cnc_rlc_pkg::CH_LT) begin
      bar = 1;
      while (bar < len && line_chars[bar] != cnc_rlc_pkg::CH_BAR) bar++;
      if (bar < len) begin
        r.kind = cnc_rlc_pkg::KIND_STATUS;
        r.name_len = (bar - 1 > cnc_rlc_pkg::NAME_MAX) ? cnc_rlc_pkg::NAME_MAX
                                                       : 6'(bar - 1);
        if (text_at(1, bar - 1, "Idle")) begin
          r.idle = 1'b1;
          ready_flag = 1'b1;
        end
      end
    end else if (starts_with(len, "ALARM:")) begin
      r.kind = cnc_rlc_pkg::KIND_ALARM;
      r.code = atoi_code(6, len);
    end else if (starts_with(len, "error:")) begin
      r.kind = cnc_rlc_pkg::KIND_ERROR;
      r.code = atoi_code(6, len);
      r.ack = 1'b1;
    end
    r.ready = ready_flag;
    return r;
  endfunction

  task automatic take_rx_byte(input logic [7:0] b);
    if (b != cnc_rlc_pkg::CH_CR) begin
      if (b != cnc_rlc_pkg::CH_LF) begin
        if (line_count < LINE_MAX - 1) begin
          line_chars[line_count] = b;
          line_count++;
        end else begin
          line_count = 0;
        end
      end else if (line_count != 0) begin
        predicted_lines.push_back(classify_line());
        line_count = 0;
      end
    end
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cnc_rlc_pkg::result_t want;
    if (!rst_ni) begin
      line_count = 0;
      ready_flag = 1'b0;
      mismatch_total = 0;
      predicted_lines.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (predicted_lines.size() == 0) begin
          mismatch_total++;
          $display("%0t: line result with no prediction, kind %0d", $time, line_kind_i);
        end else begin
          want = predicted_lines.pop_front();
          check_field("line_kind", want.kind, line_kind_i);
          check_field("reported_code", want.code, reported_code_i);
          check_field("state_is_idle", want.idle, state_is_idle_i);
          check_field("state_name_length", want.name_len, state_name_length_i);
          check_field("ack_released", want.ack, ack_released_i);
          check_field("controller_ready", want.ready, controller_ready_i);
        end
      end
      if (push_i && !full_i) take_rx_byte(rx_byte_i);
    end
    lines_pending_o = predicted_lines.size();
    mismatches_o = mismatch_total;
  end

endmodule

/* bench/cnc_response_line_classifier_test.sv */
// byte stimulus and verdict for the response line classifier
module cnc_response_line_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX    = 64;
  localparam int RANDOM_RX   = 1050;    // random bytes after the directed lines
  localparam int CALM_RX     = 300;     // first random bytes sent with no idling on either side
  localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest legal run

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               push      = 1'b0;
  logic               pop       = 1'b0;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               full;
  logic               empty;
  logic [2:0]         line_kind_o;
  logic signed [16:0] reported_code_o;
  logic               state_is_idle_o;
  logic [5:0]         state_name_length_o;
  logic               ack_released_o;
  logic               controller_ready_o;

  int lines_pending;
  int mismatches;
  int cycle_count   = 0;
  int rx_transfers  = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 25;

  // characters of the line being built, newline is added on sending
  logic [7:0] line_buf [$];

  cnc_response_line_classifier #(
    .LINE_MAX(LINE_MAX)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte_i),
    .empty              (empty),
    .pop                (pop),
    .line_kind_o        (line_kind_o),
    .reported_code_o    (reported_code_o),
    .state_is_idle_o    (state_is_idle_o),
    .state_name_length_o(state_name_length_o),
    .ack_released_o     (ack_released_o),
    .controller_ready_o (controller_ready_o)
  );

  cnc_rlc_response_checker #(
    .LINE_MAX(LINE_MAX)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_i             (full),
    .rx_byte_i          (rx_byte_i),
    .empty_i            (empty),
    .pop_i              (pop),
    .line_kind_i        (line_kind_o),
    .reported_code_i    (reported_code_o),
    .state_is_idle_i    (state_is_idle_o),
    .state_name_length_i(state_name_length_o),
    .ack_released_i     (ack_released_o),
    .controller_ready_i (controller_ready_o),
    .lines_pending_o    (lines_pending),
    .mismatches_o       (mismatches)
  );

  always #4 clk_i = ~clk_i;

  // result side: pop held low in about a quarter of the cycles, never in the calm stretch
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: a hang or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one byte transfer; push stays high into the next call unless that call idles
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    rx_transfers++;
  endtask

  // sends the built line with the odd carriage return mixed in, then the newline
  task automatic send_line();
    foreach (line_buf[i]) begin
      if ($urandom_range(19) == 0) send_byte(cnc_rlc_pkg::CH_CR);
      send_byte(line_buf[i]);
    end
    send_byte(cnc_rlc_pkg::CH_LF);
    line_buf.delete();
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic add_random(input int unsigned n, input int unsigned lo, input int unsigned hi);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(hi, lo));
      line_buf.push_back(b);
    end
  endtask

  // stop sending until every predicted line has come out
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (lines_pending != 0) @(posedge clk_i);
  endtask

  // mostly well-formed responses with random content, some noise and broken lines
  task automatic make_random_line();
    int unsigned pick;
    int unsigned k;
    line_buf.delete();
    pick = $urandom_range(99);
    if (pick < 22) begin
      // ok or READY, now and then spoiled or cut short by a zero byte
      if (pick < 12) add_text("ok");
      else add_text("READY");
      case ($urandom_range(5))
        2: begin
          line_buf.push_back(cnc_rlc_pkg::CH_NUL);
          add_random($urandom_range(1, 4), 0, 255);
        end
        3: add_random(1, 32, 126);
        4: line_buf.delete(line_buf.size() - 1);
        default: ;
      endcase
    end else if (pick < 47) begin
      // status: state name, bar, field text
      line_buf.push_back(cnc_rlc_pkg::CH_LT);
      k = $urandom_range(9);
      if (k < 3) begin
        add_text("Idle");
      end else if (k == 3) begin
        add_text("Idl");
        add_random(1, 100, 102);
      end else if (k == 4) begin
        add_random($urandom_range(30, 61), 65, 122);
      end else begin
        add_random($urandom_range(0, 8), 65, 122);
      end
      if ($urandom_range(9) != 0) line_buf.push_back(cnc_rlc_pkg::CH_BAR);
      add_random($urandom_range(0, 20), 32, 126);
    end else if (pick < 77) begin
      // alarm or error with a code that may carry blanks, a sign and too many digits
      add_text(pick < 62 ? "ALARM:" : "error:");
      if ($urandom_range(9) == 0) line_buf[$urandom_range(5)] = 8'($urandom_range(126, 32));
      repeat ($urandom_range(2)) begin
        if ($urandom_range(1) == 0) line_buf.push_back(cnc_rlc_pkg::CH_SPACE);
        else add_random(1, 9, 12);
      end
      case ($urandom_range(3))
        1: line_buf.push_back(cnc_rlc_pkg::CH_PLUS);
        2: line_buf.push_back(cnc_rlc_pkg::CH_MINUS);
        default: ;
      endcase
      add_random($urandom_range(0, 7), 48, 57);
      if ($urandom_range(3) == 0) add_random($urandom_range(1, 5), 32, 126);
    end else if (pick < 87) begin
      // raw noise over the whole byte range, embedded newlines split it further
      add_random($urandom_range(1, 12), 0, 255);
    end else if (pick < 92) begin
      // long, mostly enough to run past the line store and restart
      add_random($urandom_range(60, 80), 32, 126);
    end else if (pick < 96) begin
      line_buf.push_back(cnc_rlc_pkg::CH_NUL);
      add_random($urandom_range(0, 6), 32, 126);
    end
    // remaining picks send a bare newline
    if (line_buf.size() > 0 && $urandom_range(29) == 0)
      line_buf[$urandom_range(line_buf.size() - 1)] = cnc_rlc_pkg::CH_NUL;
  endtask

  initial begin : stimulus
    int random_start;
    logic drained;
    drained = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines: each kind, code extremes, missing bar, zero bytes, full line
    send_byte(cnc_rlc_pkg::CH_LF);    // empty line gives nothing
    send_text("ok");
    send_text("error:-65536");        // negative code saturates
    send_text("ALARM:\t +70000x");    // blanks, plus sign, saturation
    send_text("ALARM:");              // no digits
    send_text("<Run|MPos:0");         // status, not idle, ready still low
    send_text("<Idle");               // status with no bar
    send_text("<Idle|WPos:1");        // idle status raises ready
    send_text("READY");
    send_text("ok ");
    line_buf.push_back(cnc_rlc_pkg::CH_NUL); // line that starts with a zero byte
    add_text("ok");
    send_line();
    add_text("ok");                   // text past a zero byte is ignored
    line_buf.push_back(cnc_rlc_pkg::CH_NUL);
    line_buf.push_back(8'hFF);
    send_line();
    add_random(LINE_MAX - 1, 97, 122); // exactly full line
    send_line();
    add_random(LINE_MAX, 97, 122);     // one too many, restarts before READY
    add_text("READY");
    send_line();
    send_text("error:65535");

    // pause until everything directed has come out
    drain();

    // random part, calm stretch first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_start = rx_transfers;
    while (rx_transfers < random_start + RANDOM_RX) begin
      if (rx_transfers >= random_start + CALM_RX) begin
        send_idle_pct = 25;
        recv_idle_pct = 25;
      end
      if (!drained && rx_transfers >= random_start + RANDOM_RX / 2) begin
        drain();
        drained = 1'b1;
      end
      make_random_line();
      send_line();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
